>>> src/mfs_pkg.sv
// Shared constants, register codes and types for the metaball field shader.
`default_nettype none
package mfs_pkg;

  // Ball register slots; lanes beyond BALL_COUNT are stored but unused.
  localparam int BALL_SLOTS    = 4;
  localparam int BALL_COUNT_DEF = 4;

  // Configuration port sizes and reset values.
  localparam int          CFG_INDEX_W  = 3;
  localparam int          CFG_DATA_W   = 32;
  localparam logic [31:0] POS_RESET    = 32'h0018_0020;
  localparam logic [15:0] RADIUS_RESET = 16'd800;

  // Field saturation and palette clamp.
  localparam logic [7:0] FIELD_CAP = 8'd254;
  localparam logic [7:0] INDEX_CAP = 8'd127;

  // Divider shape: a 16-bit quotient, four bits per pipeline stage.
  localparam int DIV_W           = 16;
  localparam int STEPS_PER_STAGE = 4;
  localparam int DIV_STAGES      = DIV_W / STEPS_PER_STAGE;

  // Register indexes on the configuration port.
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_BALL_A = 3'd0,
    REG_BALL_B = 3'd1,
    REG_BALL_C = 3'd2,
    REG_BALL_D = 3'd3,
    REG_RADIUS = 3'd4
  } reg_index_t;

  // State of one ball lane inside the restoring divider.
  typedef struct packed {
    logic [DIV_W-1:0] rem;
    logic [DIV_W-1:0] quo;
    logic [DIV_W-1:0] num;
    logic [DIV_W-1:0] dvs;
  } div_lane_t;

endpackage
`default_nettype wire

>>> src/metaball_field_shader.sv
// Metaball field shader: pipelined per-cell field sum over the ball lanes.
//
// Usage: write the ball centres (registers 0 to 3, x in the low half and y in
// the high half, two's complement) and the field radius (register 4) through
// the cfg channel while the block is idle; cfg_ready is always high and
// writes to other indexes are dropped. Cells enter on the in channel
// (pixel_x, pixel_y) and each gives one item on the out channel with its
// palette index and the echoed coordinate.
// Each cell runs through eight register stages: offsets, squares, sum, four
// divider stages of four quotient bits each, and the output register.
// Throughput is one item per cycle while the receiver takes results; every
// ball has its own lane, so the ball count does not change the rate.
// Reset clears all valid bits and loads the register reset values; the
// pipeline is empty afterwards.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and in_ready drops in the same cycle; nothing is lost or repeated, and
// in_ready returns as soon as the waiting item is taken.
`default_nettype none
module metaball_field_shader #(
  parameter int BALL_COUNT = mfs_pkg::BALL_COUNT_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // Configuration writes
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [mfs_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [mfs_pkg::CFG_DATA_W-1:0]  cfg_data,
  // Cell input
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [7:0]                     pixel_x,
  input  wire logic [7:0]                     pixel_y,
  // Result output
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [6:0]                          color_index,
  output logic [7:0]                          out_x,
  output logic [7:0]                          out_y
);
  import mfs_pkg::*;

  localparam int SUM_W = DIV_W + $clog2(BALL_SLOTS + 1);

  // Configuration registers.
  logic [31:0] ball_pos [BALL_SLOTS];
  logic [15:0] field_radius;

  // Stage 1: coordinate offsets.
  logic               s1_valid;
  logic [7:0]         s1_x, s1_y;
  logic signed [16:0] s1_dx [BALL_COUNT];
  logic signed [16:0] s1_dy [BALL_COUNT];

  // Stage 2: squares.
  logic        s2_valid;
  logic [7:0]  s2_x, s2_y;
  logic [31:0] s2_sqx [BALL_COUNT];
  logic [31:0] s2_sqy [BALL_COUNT];

  // Stage 3: divisor and numerator per lane.
  logic        s3_valid;
  logic [7:0]  s3_x, s3_y;
  div_lane_t   s3_lane [BALL_COUNT];

  // Divider stages.
  logic        dv_valid [DIV_STAGES];
  logic [7:0]  dv_x [DIV_STAGES];
  logic [7:0]  dv_y [DIV_STAGES];
  div_lane_t   dv_lane [DIV_STAGES][BALL_COUNT];
  div_lane_t   dv_next [DIV_STAGES][BALL_COUNT];

  // Field sum and palette index.
  logic [SUM_W-1:0] field_sum;
  logic [7:0]       field_sat;
  logic [7:0]       color_full;
  logic [6:0]       color_next;

  logic advance;

  // STEPS_PER_STAGE (four) restoring division steps on one lane.
  function automatic div_lane_t div_steps(input div_lane_t a);
    div_lane_t        r;
    logic [DIV_W:0]   trial;
    r = a;
    for (int s = 0; s < STEPS_PER_STAGE; s++) begin
      trial = {r.rem, r.num[DIV_W-1]};
      r.num = {r.num[DIV_W-2:0], 1'b0};
      if (trial >= {1'b0, r.dvs}) begin
        r.rem = DIV_W'(trial - {1'b0, r.dvs});
        r.quo = {r.quo[DIV_W-2:0], 1'b1};
      end else begin
        r.rem = trial[DIV_W-1:0];
        r.quo = {r.quo[DIV_W-2:0], 1'b0};
      end
    end
    return r;
  endfunction

  // The whole pipeline moves unless a finished item waits at the output.
  assign advance   = !out_valid || out_ready;
  assign in_ready  = advance;
  assign cfg_ready = 1'b1;

  // Register file writes; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int b = 0; b < BALL_SLOTS; b++) ball_pos[b] <= POS_RESET;
      field_radius <= RADIUS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_BALL_A: ball_pos[0] <= cfg_data;
        REG_BALL_B: ball_pos[1] <= cfg_data;
        REG_BALL_C: ball_pos[2] <= cfg_data;
        REG_BALL_D: ball_pos[3] <= cfg_data;
        REG_RADIUS: field_radius <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Valid bits travel with the data and clear on reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      for (int k = 0; k < DIV_STAGES; k++) dv_valid[k] <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      s1_valid  <= in_valid;
      s2_valid  <= s1_valid;
      s3_valid  <= s2_valid;
      dv_valid[0] <= s3_valid;
      for (int k = 1; k < DIV_STAGES; k++) dv_valid[k] <= dv_valid[k-1];
      out_valid <= dv_valid[DIV_STAGES-1];
    end
  end

  // Coordinate echo through the pipeline.
  always_ff @(posedge clk) begin
    if (advance) begin
      s1_x <= pixel_x;
      s1_y <= pixel_y;
      s2_x <= s1_x;
      s2_y <= s1_y;
      s3_x <= s2_x;
      s3_y <= s2_y;
      dv_x[0] <= s3_x;
      dv_y[0] <= s3_y;
      for (int k = 1; k < DIV_STAGES; k++) begin
        dv_x[k] <= dv_x[k-1];
        dv_y[k] <= dv_y[k-1];
      end
      out_x <= dv_x[DIV_STAGES-1];
      out_y <= dv_y[DIV_STAGES-1];
    end
  end

  // Per-ball lanes: offsets, squares, divisor setup and division.
  for (genvar b = 0; b < BALL_COUNT; b++) begin : g_lane
    logic signed [33:0] prod_x, prod_y;
    logic [32:0]        dsq;
    logic               far;

    assign prod_x = 34'(s1_dx[b]) * 34'(s1_dx[b]);
    assign prod_y = 34'(s1_dy[b]) * 34'(s1_dy[b]);
    assign dsq    = {1'b0, s2_sqx[b]} + {1'b0, s2_sqy[b]};
    // A squared distance above the radius range always gives a zero quotient.
    assign far    = |dsq[32:DIV_W];

    always_ff @(posedge clk) begin
      if (advance) begin
        s1_dx[b]  <= $signed({9'd0, pixel_x}) -
                     $signed({ball_pos[b][15], ball_pos[b][15:0]});
        s1_dy[b]  <= $signed({9'd0, pixel_y}) -
                     $signed({ball_pos[b][31], ball_pos[b][31:16]});
        s2_sqx[b] <= prod_x[31:0];
        s2_sqy[b] <= prod_y[31:0];
        s3_lane[b].rem <= '0;
        s3_lane[b].quo <= '0;
        if (far) begin
          s3_lane[b].num <= '0;
          s3_lane[b].dvs <= '1;
        end else begin
          s3_lane[b].num <= field_radius;
          // A cell on the centre counts as distance one.
          s3_lane[b].dvs <= (dsq[DIV_W-1:0] == '0) ? DIV_W'(1) : dsq[DIV_W-1:0];
        end
      end
    end

    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
      if (k == 0) begin : g_first
        assign dv_next[k][b] = div_steps(s3_lane[b]);
      end else begin : g_rest
        assign dv_next[k][b] = div_steps(dv_lane[k-1][b]);
      end

      always_ff @(posedge clk) begin
        if (advance) dv_lane[k][b] <= dv_next[k][b];
      end
    end
  end

  // Sum the quotients, saturate the field and form the palette index.
  always_comb begin
    field_sum = '0;
    for (int b = 0; b < BALL_COUNT; b++) begin
      field_sum = field_sum + SUM_W'(dv_lane[DIV_STAGES-1][b].quo);
    end
    field_sat  = (field_sum > SUM_W'(FIELD_CAP)) ? FIELD_CAP : field_sum[7:0];
    color_full = 8'd1 + {1'b0, field_sat[7:1]};
    color_next = (color_full > INDEX_CAP) ? INDEX_CAP[6:0] : color_full[6:0];
  end

  always_ff @(posedge clk) begin
    if (advance) color_index <= color_next;
  end

`ifndef NO_ASSERTIONS
  // The palette index of a delivered item is never zero.
  a_index_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> color_index != 7'd0)
    else $error("zero palette index on a delivered item");

  // A radius write lands in the register on the next cycle.
  a_radius_write: assert property (@(posedge clk) disable iff (rst)
    (cfg_valid && cfg_ready && cfg_index == REG_RADIUS)
      |=> field_radius == $past(cfg_data[15:0]))
    else $error("field radius write lost");

  // The remainder of ball lane 0 in the first divider stage stays below its divisor.
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    dv_valid[0] |-> dv_lane[0][0].rem < dv_lane[0][0].dvs)
    else $error("divider remainder out of range");

  // A stalled output holds the last divider stage in place.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> $stable(dv_valid[DIV_STAGES-1]) &&
      $stable(dv_lane[DIV_STAGES-1][0].quo))
    else $error("pipeline moved during a stall");
`endif

endmodule
`default_nettype wire
